### design/cvfb_pkg.sv
// Package for the cell voltage CAN frame builder.
// Holds the transaction structs, the queue entry and the shared constants.
// No dependencies.
`default_nettype none

package cvfb_pkg;

  localparam int unsigned CellsInModule = 6;
  localparam int unsigned CellsInFrame  = 3;
  localparam int unsigned UvWidth       = 26;
  localparam int unsigned MvWidth       = 16;
  localparam int unsigned QuotWidth     = 17;
  localparam int unsigned PosWidth      = 9;

  localparam logic [10:0] IdLowHalf  = 11'h400;
  localparam logic [10:0] IdHighHalf = 11'h401;

  // floor(2^36 / 1000); the quotient estimate is exact or one short
  localparam logic [26:0] MvRecip    = 27'd68719476;
  localparam int unsigned RecipShift = 36;
  localparam logic [9:0]  UvPerMv    = 10'd1000;

  localparam logic [7:0] CrcPoly   = 8'h2F;
  localparam logic [7:0] CrcInit   = 8'hFF;
  localparam logic [7:0] CrcXorOut = 8'hFF;

  typedef struct packed {
    logic [5:0]  module_index;
    logic [7:0]  cell_count;
    logic [25:0] cell_uv_1;
    logic [25:0] cell_uv_2;
    logic [25:0] cell_uv_3;
    logic [25:0] cell_uv_4;
    logic [25:0] cell_uv_5;
    logic [25:0] cell_uv_6;
  } cvfb_item_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [5:0]  frame_module;
    logic [15:0] first_mv;
    logic [15:0] second_mv;
    logic [15:0] third_mv;
    logic [7:0]  frame_crc;
    logic        last_frame;
  } cvfb_result_t;

  // classified item as held in the queue
  typedef struct packed {
    logic [5:0]                              module_index;
    logic [CellsInModule-1:0]                cell_ok;
    logic [CellsInModule-1:0][UvWidth-1:0]   cell_uv;
  } cvfb_entry_t;

endpackage

`default_nettype wire

### design/cvfb_front.sv
// Front end: classifies an accepted transaction, marking cells inside the pack.
// Depends on cvfb_pkg.
`default_nettype none

module cvfb_front (
  input  cvfb_pkg::cvfb_item_t  item_i,
  output cvfb_pkg::cvfb_entry_t entry_o
);
  import cvfb_pkg::*;

  logic [PosWidth-1:0] base_pos;

  assign base_pos = PosWidth'(item_i.module_index) * PosWidth'(CellsInModule);

  always_comb begin
    entry_o.module_index = item_i.module_index;
    entry_o.cell_uv[0]   = item_i.cell_uv_1;
    entry_o.cell_uv[1]   = item_i.cell_uv_2;
    entry_o.cell_uv[2]   = item_i.cell_uv_3;
    entry_o.cell_uv[3]   = item_i.cell_uv_4;
    entry_o.cell_uv[4]   = item_i.cell_uv_5;
    entry_o.cell_uv[5]   = item_i.cell_uv_6;
    for (int s = 0; s < CellsInModule; s++) begin
      entry_o.cell_ok[s] = (base_pos + PosWidth'(s)) < PosWidth'(item_i.cell_count);
    end
  end

endmodule

`default_nettype wire

### design/cvfb_queue.sv
// Two-entry queue between the front end and the frame back end.
// Depends on cvfb_pkg.
`default_nettype none

module cvfb_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  cvfb_pkg::cvfb_entry_t push_data_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output cvfb_pkg::cvfb_entry_t pop_data_o
);
  import cvfb_pkg::*;

  cvfb_entry_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### design/cvfb_back.sv
// Back end: builds one frame per cycle from queued entries while the queue is not empty.
// Stages: reciprocal multiply, quotient fix-up and saturation, CRC in two halves.
// Depends on cvfb_pkg.
`default_nettype none

module cvfb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  cvfb_pkg::cvfb_entry_t  entry_i,
  output logic                   pop_o,
  output logic                   result_valid_o,
  output cvfb_pkg::cvfb_result_t result_o
);
  import cvfb_pkg::*;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  logic half_q, half_d;
  logic issue;

  // stage 1: quotient estimates
  logic                                 s1_vld_q;
  logic                                 s1_last_q;
  logic [5:0]                           s1_module_q;
  logic [CellsInFrame-1:0]              s1_ok_q;
  logic [CellsInFrame-1:0][UvWidth-1:0] s1_uv_q;
  logic [CellsInFrame-1:0][QuotWidth-1:0] s1_q0_q;
  logic [CellsInFrame-1:0][UvWidth-1:0] sel_uv;
  logic [CellsInFrame-1:0]              sel_ok;
  logic [CellsInFrame-1:0][QuotWidth-1:0] q0_d;

  // stage 2: millivolt values
  logic                                 s2_vld_q;
  logic                                 s2_last_q;
  logic [5:0]                           s2_module_q;
  logic [CellsInFrame-1:0][MvWidth-1:0] s2_mv_q, s2_mv_d;

  // stage 3: CRC over bytes 0..3
  logic                                 s3_vld_q;
  logic                                 s3_last_q;
  logic [5:0]                           s3_module_q;
  logic [CellsInFrame-1:0][MvWidth-1:0] s3_mv_q;
  logic [7:0]                           s3_crc_q, s3_crc_d;

  logic                                 out_vld_q;
  cvfb_result_t                         out_q, out_d;

  assign issue = !empty_i;
  assign pop_o = issue && half_q;
  assign half_d = issue ? ~half_q : half_q;

  always_comb begin
    for (int i = 0; i < CellsInFrame; i++) begin
      sel_uv[i] = half_q ? entry_i.cell_uv[i + CellsInFrame] : entry_i.cell_uv[i];
      sel_ok[i] = half_q ? entry_i.cell_ok[i + CellsInFrame] : entry_i.cell_ok[i];
      q0_d[i]   = QuotWidth'((53'(sel_uv[i]) * 53'(MvRecip)) >> RecipShift);
    end
  end

  always_comb begin
    logic [UvWidth-1:0]   prod;
    logic [UvWidth-1:0]   rem;
    logic [QuotWidth-1:0] q;
    for (int i = 0; i < CellsInFrame; i++) begin
      prod = UvWidth'(27'(s1_q0_q[i]) * 27'(UvPerMv));
      rem  = s1_uv_q[i] - prod;
      q    = s1_q0_q[i] + QuotWidth'(rem >= UvWidth'(UvPerMv));
      if (!s1_ok_q[i]) begin
        s2_mv_d[i] = '0;
      end else if (q[QuotWidth-1]) begin
        s2_mv_d[i] = '1;
      end else begin
        s2_mv_d[i] = q[MvWidth-1:0];
      end
    end
  end

  always_comb begin
    logic [7:0] c;
    c = crc_byte(CrcInit, {2'b00, s2_module_q});
    c = crc_byte(c, s2_mv_q[0][7:0]);
    c = crc_byte(c, s2_mv_q[0][15:8]);
    c = crc_byte(c, s2_mv_q[1][7:0]);
    s3_crc_d = c;
  end

  always_comb begin
    logic [7:0] c;
    c = crc_byte(s3_crc_q, s3_mv_q[1][15:8]);
    c = crc_byte(c, s3_mv_q[2][7:0]);
    c = crc_byte(c, s3_mv_q[2][15:8]);
    out_d.frame_id     = s3_last_q ? IdHighHalf : IdLowHalf;
    out_d.frame_module = s3_module_q;
    out_d.first_mv     = s3_mv_q[0];
    out_d.second_mv    = s3_mv_q[1];
    out_d.third_mv     = s3_mv_q[2];
    out_d.frame_crc    = c ^ CrcXorOut;
    out_d.last_frame   = s3_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      half_q    <= half_d;
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q   <= half_q;
    s1_module_q <= entry_i.module_index;
    s1_ok_q     <= sel_ok;
    s1_uv_q     <= sel_uv;
    s1_q0_q     <= q0_d;
    s2_last_q   <= s1_last_q;
    s2_module_q <= s1_module_q;
    s2_mv_q     <= s2_mv_d;
    s3_last_q   <= s2_last_q;
    s3_module_q <= s2_module_q;
    s3_mv_q     <= s2_mv_q;
    s3_crc_q    <= s3_crc_d;
    out_q       <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

`default_nettype wire

### design/cell_voltage_can_frame_builder.sv
// Channel  | Signals                    | Transaction
// ---------+----------------------------+------------------------------------------
// command  | start, busy, item_i        | start high and busy low at a rising edge
// result   | result_valid_o, result_o   | result_valid_o high, one cycle per frame
//
// Each command yields two frames, 0x400 then 0x401, on consecutive cycles.
// The back end issues one frame a cycle while the queue holds an entry, so sustained, one
// command is taken per two frames; the two-entry queue lets start follow in the next cycle.
// After the accepting edge the first frame is registered in stages 1, 2, 3 and the output.
// busy is high only while the queue holds two commands. Results cannot be stalled.
// Reset is asynchronous, active low, and empties the queue and the pipeline.
// Depends on cvfb_pkg, cvfb_front, cvfb_queue and cvfb_back.
`default_nettype none

module cell_voltage_can_frame_builder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  cvfb_pkg::cvfb_item_t   item_i,
  output logic                   result_valid_o,
  output cvfb_pkg::cvfb_result_t result_o
);
  import cvfb_pkg::*;

  cvfb_entry_t front_entry;
  cvfb_entry_t queue_entry;
  logic        queue_full;
  logic        queue_empty;
  logic        back_pop;

  cvfb_front u_front (
    .item_i  (item_i),
    .entry_o (front_entry)
  );

  cvfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start),
    .push_data_i (front_entry),
    .full_o      (queue_full),
    .empty_o     (queue_empty),
    .pop_i       (back_pop),
    .pop_data_o  (queue_entry)
  );

  cvfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (queue_empty),
    .entry_i        (queue_entry),
    .pop_o          (back_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  assign busy = queue_full;

endmodule

`default_nettype wire
